// ===== src/breakpoint_table_core_defines.svh =====
// Assertion macros for the breakpoint table core.
// Depends on nothing; included by the top level, which supplies clk and rst_n.
`ifndef BREAKPOINT_TABLE_CORE_DEFINES_SVH
`define BREAKPOINT_TABLE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Antecedent holds, consequent must hold on the following clock edge.
`define BPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("breakpoint table: next-cycle check failed");
// Antecedent holds, consequent must hold on the same clock edge.
`define BPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("breakpoint table: same-cycle check failed");
`else
`define BPT_ASSERT_NEXT(lbl, ante, cons)
`define BPT_ASSERT_SAME(lbl, ante, cons)
`endif

`endif

// ===== src/bpt_pkg.sv =====
// Shared types and codes for the breakpoint table core.
// Depends on nothing; used by the interfaces, the top level, the controller and the datapath.
package bpt_pkg;

    typedef logic [2:0]  mode_t;
    typedef logic [31:0] pc_t;
    typedef logic [15:0] line_t;
    typedef logic [1:0]  status_t;
    typedef logic [3:0]  count_out_t;

    // Request modes; the remaining codes are no-ops.
    localparam mode_t MODE_LOOKUP = 3'd0;
    localparam mode_t MODE_QUERY  = 3'd1;
    localparam mode_t MODE_INSERT = 3'd2;
    localparam mode_t MODE_REMOVE = 3'd3;
    localparam mode_t MODE_CLEAR  = 3'd4;

    // Result status codes.
    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_MISS = 2'd1;
    localparam status_t STATUS_FULL = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic scan_rd;
        logic finish;
    } bpt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_valid;
        logic scan_last;
        logic out_free;
    } bpt_sts_t;

endpackage

// ===== src/bpt_if.sv =====
// Request and response channel interfaces for the breakpoint table core.
// Depends on bpt_pkg for the payload types.
interface bpt_req_if;
    logic               valid;
    logic               ready;
    bpt_pkg::mode_t     mode;
    bpt_pkg::pc_t       pc_value;
    bpt_pkg::line_t     line_number;

    modport source (output valid, output mode, output pc_value, output line_number,
                    input ready);
    modport sink   (input valid, input mode, input pc_value, input line_number,
                    output ready);
endinterface

interface bpt_rsp_if;
    logic                  valid;
    logic                  ready;
    logic                  ok;
    bpt_pkg::line_t        found_line;
    bpt_pkg::status_t      status;
    bpt_pkg::count_out_t   entry_count;

    modport source (output valid, output ok, output found_line, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input ok, input found_line, input status,
                    input entry_count, output ready);
endinterface

// ===== src/breakpoint_table_core.sv =====
// Breakpoint table core: pc/line entries scanned one per cycle from a dual-port entry memory.
// A word's response follows its scan and drain, and is registered once the output register is free.
// Only one word is handled at a time: the next word is not taken until the last one is finished.
// A new word is accepted while an earlier response still waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the table at once; no clearing pass.
`include "breakpoint_table_core_defines.svh"

module breakpoint_table_core #(
    parameter int MAX_ENTRIES = 8
) (
    input logic       clk,
    input logic       rst_n,
    bpt_req_if.sink   req,
    bpt_rsp_if.source rsp
);
    import bpt_pkg::*;

    bpt_cmd_t cmd;
    bpt_sts_t sts;

    // Sequencing.
    bpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Storage, compare and response.
    bpt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

    // Only one word is in flight: the block stops taking words right after one.
    `BPT_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)
    // Finishing a word always presents a response on the next cycle.
    `BPT_ASSERT_NEXT(a_finish_gives_rsp, cmd.finish, rsp.valid)
    // A response only appears as the result of a finished word.
    `BPT_ASSERT_SAME(a_rsp_from_finish, $rose(rsp.valid), $past(cmd.finish))

endmodule

// ===== src/bpt_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module bpt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bpt_ctrl.sv =====
// Controller state machine for the breakpoint table: accept, scan, drain, finish.
// Depends on bpt_pkg for the state, command and status types.
module bpt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  bpt_pkg::bpt_sts_t sts,
    output bpt_pkg::bpt_cmd_t cmd
);
    import bpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_DONE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/bpt_datapath.sv =====
// Datapath of the breakpoint table: request registers, entry memory scan,
// match tracking, table update and the response register. Depends on bpt_pkg, bpt_if and bpt_ram.
module bpt_datapath #(
    parameter int MAX_ENTRIES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bpt_pkg::bpt_cmd_t cmd,
    output bpt_pkg::bpt_sts_t sts,
    bpt_req_if.sink           req,
    bpt_rsp_if.source         rsp
);
    import bpt_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = $bits(pc_t) + $bits(line_t);

    // Table state.
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    // Captured request.
    mode_t req_mode_reg;
    pc_t   req_pc_reg;
    line_t req_line_reg;

    // Scan and compare stage.
    logic [AW-1:0] scan_idx_reg;
    logic          cmp_vld_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic          hit_reg;
    logic [AW-1:0] best_idx_reg;
    pc_t           best_pc_reg;
    line_t         hit_line_reg;

    // Response register.
    logic       out_valid_reg;
    logic       ok_reg;
    line_t      found_line_reg;
    status_t    status_reg;
    count_out_t entry_count_reg;

    logic          accept;
    logic [EW-1:0] rd_entry;
    pc_t           rd_pc;
    line_t         rd_line;
    logic          take;
    logic [AW-1:0] free_idx;
    logic          full;
    logic          ram_we;
    logic          ok_next;
    line_t         found_next;
    status_t       status_next;
    logic [CW+3:0] count_ext;

    assign accept    = cmd.in_ready & req.valid;
    assign req.ready = cmd.in_ready;

    assign sts.req_valid = req.valid;
    assign sts.scan_last = (scan_idx_reg == AW'(MAX_ENTRIES - 1));
    assign sts.out_free  = !out_valid_reg || rsp.ready;

    // Entry memory holding {pc, line}.
    bpt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata ({req_pc_reg, req_line_reg}),
        .re    (cmd.scan_rd),
        .raddr (scan_idx_reg),
        .rdata (rd_entry)
    );

    assign rd_pc   = rd_entry[EW-1 -: $bits(pc_t)];
    assign rd_line = rd_entry[$bits(line_t)-1:0];

    // Request capture, no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_mode_reg <= req.mode;
            req_pc_reg   <= req.pc_value;
            req_line_reg <= req.line_number;
        end
    end

    // Scan address counter and compare-stage tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan_rd;
            cmp_idx_reg <= scan_idx_reg;
            if (accept)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
            end
        end
    end

    // Decide whether the entry just read is a better match.
    always_comb
    begin
        take = 1'b0;
        case (req_mode_reg)
            MODE_LOOKUP, MODE_INSERT:
            begin
                take = (rd_pc == req_pc_reg);
            end
            MODE_QUERY, MODE_REMOVE:
            begin
                take = (rd_line == req_line_reg) && (!hit_reg || (rd_pc < best_pc_reg));
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
    end

    // Match flag and best entry so far.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmp_vld_reg && valid_reg[cmp_idx_reg] && take)
        begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_vld_reg && valid_reg[cmp_idx_reg] && take)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_pc_reg  <= rd_pc;
            hit_line_reg <= rd_line;
        end
    end

    // Lowest free slot for an insert.
    always_comb
    begin
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = AW'(i);
            end
        end
    end

    assign full = (count_reg == CW'(MAX_ENTRIES));

    // Result and table update for the finished request.
    always_comb
    begin
        ok_next     = 1'b0;
        found_next  = '0;
        status_next = STATUS_MISS;
        valid_next  = valid_reg;
        count_next  = count_reg;
        ram_we      = 1'b0;
        case (req_mode_reg)
            MODE_LOOKUP:
            begin
                if (hit_reg)
                begin
                    ok_next     = 1'b1;
                    found_next  = hit_line_reg;
                    status_next = STATUS_OK;
                end
            end
            MODE_QUERY:
            begin
                if (hit_reg)
                begin
                    ok_next     = 1'b1;
                    status_next = STATUS_OK;
                end
            end
            MODE_INSERT:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else if (!hit_reg)
                begin
                    ok_next              = 1'b1;
                    status_next          = STATUS_OK;
                    valid_next[free_idx] = 1'b1;
                    count_next           = count_reg + CW'(1);
                    ram_we               = cmd.finish;
                end
            end
            MODE_REMOVE:
            begin
                if (hit_reg)
                begin
                    ok_next                  = 1'b1;
                    status_next              = STATUS_OK;
                    valid_next[best_idx_reg] = 1'b0;
                    count_next               = count_reg - CW'(1);
                end
            end
            MODE_CLEAR:
            begin
                ok_next     = 1'b1;
                status_next = STATUS_OK;
                valid_next  = '0;
                count_next  = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign count_ext = {4'b0, count_next};

    // Table valid bits and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.finish)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // Response valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            ok_reg          <= ok_next;
            found_line_reg  <= found_next;
            status_reg      <= status_next;
            entry_count_reg <= count_ext[3:0];
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = ok_reg;
    assign rsp.found_line  = found_line_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = entry_count_reg;

endmodule
